@@ design/lbs_pkg.sv @@
// lbs_pkg: shared types, codes and helpers of the skinning block
// no dependencies
package lbs_pkg;

  localparam int unsigned JointCount     = 256;
  localparam int unsigned MaxInfluences  = 16;
  localparam int unsigned EntriesPerJoint = 12;
  localparam logic [16:0] OneQ16 = 17'd65536;

  // operation codes
  localparam logic [2:0] OP_LOAD      = 3'd0;
  localparam logic [2:0] OP_POSITION  = 3'd1;
  localparam logic [2:0] OP_NORMAL    = 3'd2;
  localparam logic [2:0] OP_TANGENT   = 3'd3;
  localparam logic [2:0] OP_INFLUENCE = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_INFL_COUNT = 2'd0;
  localparam logic [1:0] REG_NRM_EN     = 2'd1;
  localparam logic [1:0] REG_TAN_EN     = 2'd2;

  localparam logic [1:0] ROW_TRANSLATION = 2'd3;
  localparam logic [1:0] VEC_POSITION    = 2'd0;

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         joint;
    logic [3:0]         element;
    logic signed [31:0] value;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [16:0]        weight;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic signed [31:0] tan_x;
    logic signed [31:0] tan_y;
    logic signed [31:0] tan_z;
  } out_t;

  // one matrix product step travelling down the blend pipeline
  typedef struct packed {
    logic       valid;
    logic [1:0] vsel;
    logic [1:0] col;
    logic [1:0] row;
  } tag_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ design/lbs_mem.sv @@
// lbs_mem: joint matrix store, one write port and one registered read port
// depends on nothing
module lbs_mem #(
  parameter int unsigned Depth = 3072,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem_q [Depth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/lbs_blend.sv @@
// lbs_blend: multiply pipeline for matrix terms and weights, plus the nine accumulators
// depends on lbs_pkg
module lbs_blend (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lbs_pkg::tag_t             tag_i,
  input  logic [31:0]               rdata_i,
  input  logic                      jvalid_i,
  input  logic [2:0][2:0][31:0]     holds_i,
  input  logic signed [20:0]        weight_i,
  input  logic                      clear_i,
  output logic [8:0][63:0]          acc_o,
  output logic                      busy_o
);
  import lbs_pkg::*;

  tag_t tag1_q, tag2_q, tag3_q, tag4_q;
  logic signed [31:0] vop, mop;
  logic signed [63:0] prod_d, prod2_q;
  logic signed [49:0] term, tsum_next, tsum_q;
  logic signed [31:0] t3_q;
  logic signed [52:0] tw_d, tw4_q;
  logic [8:0][63:0]   acc_q;
  logic [3:0]         aidx;

  // stage 1: matrix entry times vector component
  always_comb begin
    mop = jvalid_i ? $signed(rdata_i) : 32'sd0;
    case (tag1_q.row)
      ROW_TRANSLATION: vop = (tag1_q.vsel == VEC_POSITION) ? 32'sd65536 : 32'sd0;
      default:         vop = $signed(holds_i[tag1_q.vsel][tag1_q.row]);
    endcase
    prod_d = vop * mop;
  end

  // stage 2: row sum with floor shift, saturate at the translation row
  assign term      = 50'(prod2_q >>> 16);
  assign tsum_next = ((tag2_q.row == 2'd0) ? 50'sd0 : tsum_q) + term;

  // stage 3: weight scaling
  assign tw_d = t3_q * weight_i;

  // stage 4: accumulate
  assign aidx = 4'({2'b0, tag4_q.vsel} * 4'd3 + {2'b0, tag4_q.col});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
      acc_q  <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= '{valid: tag2_q.valid && (tag2_q.row == ROW_TRANSLATION),
                  vsel: tag2_q.vsel, col: tag2_q.col, row: tag2_q.row};
      tag4_q <= tag3_q;
      if (clear_i) begin
        acc_q <= '0;
      end else if (tag4_q.valid) begin
        acc_q[aidx] <= acc_q[aidx] + 64'(tw4_q >>> 16);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod2_q <= prod_d;
    if (tag2_q.valid) begin
      tsum_q <= tsum_next;
    end
    if (tag2_q.valid && tag2_q.row == ROW_TRANSLATION) begin
      t3_q <= sat32(64'(tsum_next));
    end
    tw4_q <= tw_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = tag1_q.valid | tag2_q.valid | tag3_q.valid | tag4_q.valid;

endmodule

@@ design/linear_blend_skinning.sv @@
// linear_blend_skinning: loads, vertex holds, influence control, result register
// an influence issues one matrix store read and one product per cycle for each of
// n = 1, 2 or 3 blended vectors; loads and vector items are taken while idle
// a result is loaded in the emit state after the pipeline drains; next input is taken only in idle
// reset: asynchronous active low, clears control, holds, accumulators and enables, sets the count to one
module linear_blend_skinning #(
  parameter int unsigned JOINT_COUNT = lbs_pkg::JointCount
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [4:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lbs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lbs_pkg::out_t out_data_o
);
  import lbs_pkg::*;

  localparam int unsigned Depth = JOINT_COUNT * EntriesPerJoint;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [4:0] count_q;
  logic       nrm_en_q, tan_en_q;

  // vertex holds, [vector][component]
  logic [2:0][2:0][31:0] holds_q;

  // running blend control
  logic [19:0]        wsum_q;
  logic [4:0]         icnt_q;
  logic signed [20:0] w_q;
  logic [7:0]         joint_q;
  logic               jvalid_q, last_q, do_nrm_q, do_tan_q;
  logic [1:0]         k_q, c_q, r_q, klast_q;

  // result register
  out_t out_q;
  logic out_valid_q;

  logic       in_xfer, clear_acc, mem_we, busy, jvalid_in, last_in;
  logic [6:0] count_eff;
  logic [16:0] wclip;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0] rdata;
  tag_t tag;
  logic [8:0][63:0] acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign jvalid_in = 32'(in_data_i.joint) < 32'(JOINT_COUNT);
  assign mem_we    = in_xfer && in_data_i.operation == OP_LOAD &&
                     in_data_i.element < 4'(EntriesPerJoint) && jvalid_in;
  assign waddr     = AddrW'(32'(in_data_i.joint) * 32'(EntriesPerJoint) +
                     32'(in_data_i.element));

  // effective count: zero acts as one, clipped to the maximum
  always_comb begin
    if (count_q == 5'd0) begin
      count_eff = 7'd1;
    end else if (7'(count_q) > 7'(MaxInfluences)) begin
      count_eff = 7'(MaxInfluences);
    end else begin
      count_eff = 7'(count_q);
    end
  end

  assign wclip   = (in_data_i.weight > OneQ16) ? OneQ16 : in_data_i.weight;
  assign last_in = (7'(icnt_q) + 7'd1) >= count_eff;

  // read sequence over vector, column, row
  assign raddr = AddrW'(32'(joint_q) * 32'(EntriesPerJoint) +
                 32'({2'b0, r_q} * 4'd3 + {2'b0, c_q}));
  always_comb begin
    tag       = '0;
    tag.valid = (state_q == ST_ISSUE);
    tag.vsel  = k_q;
    tag.col   = c_q;
    tag.row   = r_q;
  end

  assign clear_acc = (in_xfer && in_data_i.operation == OP_POSITION) ||
                     (state_q == ST_EMIT && (!out_valid_q || out_ready_i));

  lbs_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (in_data_i.value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lbs_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (tag),
    .rdata_i  (rdata),
    .jvalid_i (jvalid_q),
    .holds_i  (holds_q),
    .weight_i (w_q),
    .clear_i  (clear_acc),
    .acc_o    (acc),
    .busy_o   (busy)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_data_i.operation == OP_INFLUENCE) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_q == klast_q && c_q == 2'd2 && r_q == 2'd3) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!busy) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= 5'd1;
      nrm_en_q    <= 1'b0;
      tan_en_q    <= 1'b0;
      holds_q     <= '0;
      wsum_q      <= '0;
      icnt_q      <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      c_q         <= '0;
      r_q         <= '0;
    end else begin
      state_q <= state_d;

      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_INFL_COUNT: count_q  <= cfg_wdata_i;
          REG_NRM_EN:     nrm_en_q <= cfg_wdata_i[0];
          REG_TAN_EN:     tan_en_q <= cfg_wdata_i[0];
          default:        ;
        endcase
      end

      if (in_xfer) begin
        case (in_data_i.operation)
          OP_POSITION: begin
            holds_q[0] <= {in_data_i.vec_z, in_data_i.vec_y, in_data_i.vec_x};
            wsum_q     <= '0;
            icnt_q     <= '0;
          end
          OP_NORMAL:  holds_q[1] <= {in_data_i.vec_z, in_data_i.vec_y, in_data_i.vec_x};
          OP_TANGENT: holds_q[2] <= {in_data_i.vec_z, in_data_i.vec_y, in_data_i.vec_x};
          OP_INFLUENCE: begin
            if (!last_in) begin
              wsum_q <= wsum_q + 20'(wclip);
              icnt_q <= icnt_q + 5'd1;
            end
            k_q <= '0;
            c_q <= '0;
            r_q <= '0;
          end
          default: ;
        endcase
      end

      // step row, then column, then vector
      if (state_q == ST_ISSUE) begin
        r_q <= r_q + 2'd1;
        if (r_q == 2'd3) begin
          c_q <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
          if (c_q == 2'd2) begin
            k_q <= k_q + 2'd1;
          end
        end
      end

      if (state_q == ST_EMIT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
        wsum_q      <= '0;
        icnt_q      <= '0;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-influence operands, stable while the pipeline runs
  always_ff @(posedge clk_i) begin
    if (in_xfer && in_data_i.operation == OP_INFLUENCE) begin
      joint_q  <= in_data_i.joint;
      jvalid_q <= jvalid_in;
      last_q   <= last_in;
      do_nrm_q <= nrm_en_q;
      do_tan_q <= nrm_en_q && tan_en_q;
      klast_q  <= (nrm_en_q && tan_en_q) ? 2'd2 : (nrm_en_q ? 2'd1 : 2'd0);
      w_q      <= last_in ? (21'sd65536 - $signed({1'b0, wsum_q}))
                          : $signed({4'b0, wclip});
    end
    if (state_q == ST_EMIT && (!out_valid_q || out_ready_i)) begin
      out_q.pos_x <= sat32(acc[0]);
      out_q.pos_y <= sat32(acc[1]);
      out_q.pos_z <= sat32(acc[2]);
      out_q.nrm_x <= do_nrm_q ? sat32(acc[3]) : 32'sd0;
      out_q.nrm_y <= do_nrm_q ? sat32(acc[4]) : 32'sd0;
      out_q.nrm_z <= do_nrm_q ? sat32(acc[5]) : 32'sd0;
      out_q.tan_x <= do_tan_q ? sat32(acc[6]) : 32'sd0;
      out_q.tan_y <= do_tan_q ? sat32(acc[7]) : 32'sd0;
      out_q.tan_z <= do_tan_q ? sat32(acc[8]) : 32'sd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // the store is written only between items
  a_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == ST_IDLE)
    else $error("matrix store written during a blend");

  // a result is captured only after all products are accumulated
  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !busy)
    else $error("result taken with products in flight");

  // the influence counter stays below the clipped count range
  a_icnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    7'(icnt_q) < 7'(MaxInfluences))
    else $error("influence counter out of range");

  // a vector step beyond the enabled set is never issued
  a_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ISSUE |-> k_q <= klast_q)
    else $error("issue beyond last enabled vector");
`endif

endmodule
